### sv/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared widths, defaults and sequencer state type for the byte RLE encoder.
// ----------------------------------------------------------------------------
package rbe_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_BYTES  = 8;
    localparam int WORD_W      = WORD_BYTES * BYTE_W;
    localparam int NBYTES_W    = 4;
    localparam int POS_W       = 3;

    localparam int MAX_REPEAT_DEF  = 127;
    localparam int MAX_LITERAL_DEF = 128;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FCNT,
        S_FLIT,
        S_FTAIL,
        S_P1C,
        S_P1B,
        S_P2C,
        S_P2B
    } seq_state_t;

endpackage

### sv/rle_byte_encoder.sv
// ----------------------------------------------------------------------------
// rle_byte_encoder
// Run-length encoder for a byte buffer with packed 64-bit output words.
// ----------------------------------------------------------------------------
// Input channel (s_): one buffer byte per transaction, s_in_final on the last.
// Output channel (m_): packed words of 1 to 8 encoded bytes, lowest byte
// first; m_run_last closes the words of one input transaction and
// m_frame_end closes the encoded buffer.
// One input transaction is taken per idle cycle of the sequencer; the
// sequencer then emits the encoded bytes one per cycle while the packer
// has room. A byte that only extends a run or a literal group emits
// nothing and leaves the sequencer idle. A literal flush of n bytes reads
// the literal store one entry per cycle, under the same condition, after
// its count byte. m_valid rises when a word moves into the output register.
// Reset (aresetn low, synchronous) clears the run state, the sequencer and
// the packer; the literal store is not cleared.
// When m_ready is low the output register holds, the packer fills one more
// word, and then the sequencer holds until the word moves on; s_ready
// stays high only while the sequencer is idle.
// ----------------------------------------------------------------------------
module rle_byte_encoder
    import rbe_pkg::*;
#(
    parameter int MAX_REPEAT  = MAX_REPEAT_DEF,
    parameter int MAX_LITERAL = MAX_LITERAL_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_in_byte,
    input  logic                s_in_final,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [WORD_W-1:0]   m_out_word,
    output logic [NBYTES_W-1:0] m_out_bytes,
    output logic                m_run_last,
    output logic                m_frame_end
);

    localparam int LIT_AW = $clog2(MAX_LITERAL);
    localparam int CNT_W  = $clog2(MAX_LITERAL + 1);

    // run state
    logic              have_held_reg, have_held_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic [BYTE_W-1:0] gc_reg, gc_next;

    // step plan
    seq_state_t        state_reg, state_next, adv_state;
    logic [CNT_W-1:0]  fl_n_reg, fl_n_next;
    logic              tail_reg, tail_next;
    logic              p1_reg, p1_next;
    logic              p2_reg, p2_next;
    logic [BYTE_W-1:0] cnt1_reg, cnt1_next;
    logic [BYTE_W-1:0] cnt2_reg, cnt2_next;
    logic [BYTE_W-1:0] h1_reg, h1_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic              fin_reg, fin_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  idx_inc;

    // decision for the incoming byte
    logic [BYTE_W-1:0] rep, lit, rep1, lit1, g_mid;
    logic [BYTE_W-1:0] d_fl_n, d_cnt1, d_cnt2, d_gc;
    logic              d_tail, d_p1, d_p2, d_we;

    // literal store
    logic [BYTE_W-1:0] lit_mem [MAX_LITERAL];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;

    // byte stream into the packer
    logic              byte_valid, byte_take, byte_last;
    logic [BYTE_W-1:0] byte_val;

    // packer and output register
    logic [WORD_W-1:0]   pk_word_reg, pk_word_next;
    logic [NBYTES_W-1:0] pk_cnt_reg, pk_cnt_next;
    logic                pk_done_reg, pk_done_next;
    logic                pk_fin_reg, pk_fin_next;
    logic                pk_full, xfer, pack_free;
    logic [POS_W-1:0]    pk_pos;

    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_word_reg;
    logic [NBYTES_W-1:0] m_bytes_reg;
    logic                m_last_reg, m_end_reg;

    function automatic seq_state_t next_from(logic has_lit, logic has_tail,
                                             logic has_p1, logic has_p2);
        seq_state_t s;
        if (has_lit) begin
            s = S_FLIT;
        end else if (has_tail) begin
            s = S_FTAIL;
        end else if (has_p1) begin
            s = S_P1C;
        end else if (has_p2) begin
            s = S_P2C;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        rep    = gc_reg[BYTE_W-1] ? '0 : gc_reg;
        lit    = gc_reg[BYTE_W-1] ? (BYTE_W'(0) - gc_reg) : '0;
        rep1   = (lit != '0) ? BYTE_W'(1) : rep + BYTE_W'(1);
        lit1   = lit + BYTE_W'(1);
        g_mid  = gc_reg;
        d_fl_n = '0;
        d_tail = 1'b0;
        d_p1   = 1'b0;
        d_p2   = 1'b0;
        d_cnt1 = '0;
        d_cnt2 = '0;
        d_we   = 1'b0;
        if (!have_held_reg) begin
            g_mid = '0;
        end else if (s_in_byte == held_reg) begin
            if (lit != '0) begin
                d_fl_n = lit;
            end
            if (rep1 >= BYTE_W'(MAX_REPEAT)) begin
                d_p1   = 1'b1;
                d_cnt1 = rep1;
                g_mid  = '0;
            end else begin
                g_mid = rep1;
            end
        end else if (rep != '0) begin
            d_p1   = 1'b1;
            d_cnt1 = rep + BYTE_W'(1);
            g_mid  = '0;
        end else begin
            d_we = 1'b1;
            if (lit1 >= BYTE_W'(MAX_LITERAL)) begin
                d_fl_n = lit1;
                g_mid  = '0;
            end else begin
                g_mid = BYTE_W'(0) - lit1;
            end
        end
        if (s_in_final) begin
            if (g_mid[BYTE_W-1]) begin
                d_fl_n = BYTE_W'(0) - g_mid;
                d_tail = 1'b1;
            end else begin
                d_p2   = 1'b1;
                d_cnt2 = g_mid + BYTE_W'(1);
            end
            d_gc = '0;
        end else begin
            d_gc = g_mid;
        end
    end

    assign idx_inc = idx_reg + CNT_W'(1);

    always_comb begin
        have_held_next = have_held_reg;
        held_next      = held_reg;
        gc_next        = gc_reg;
        fl_n_next      = fl_n_reg;
        tail_next      = tail_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        cnt1_next      = cnt1_reg;
        cnt2_next      = cnt2_reg;
        h1_next        = h1_reg;
        b_next         = b_reg;
        fin_next       = fin_reg;
        idx_next       = idx_reg;
        mem_we         = 1'b0;
        byte_valid     = 1'b0;
        byte_val       = '0;
        adv_state      = state_reg;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    have_held_next = !s_in_final;
                    held_next      = s_in_final ? '0 : s_in_byte;
                    gc_next        = d_gc;
                    fl_n_next      = d_fl_n[CNT_W-1:0];
                    tail_next      = d_tail;
                    p1_next        = d_p1;
                    p2_next        = d_p2;
                    cnt1_next      = d_cnt1;
                    cnt2_next      = d_cnt2;
                    h1_next        = held_reg;
                    b_next         = s_in_byte;
                    fin_next       = s_in_final;
                    idx_next       = '0;
                    mem_we         = d_we;
                    if ((d_fl_n != '0) || d_tail) begin
                        state_next = S_FCNT;
                    end else begin
                        state_next = next_from(1'b0, 1'b0, d_p1, d_p2);
                    end
                end
            end
            S_FCNT: begin
                byte_valid = 1'b1;
                byte_val   = BYTE_W'(0) - (BYTE_W'(fl_n_reg) + BYTE_W'(tail_reg));
                adv_state  = next_from(fl_n_reg != '0, tail_reg, p1_reg, p2_reg);
            end
            S_FLIT: begin
                byte_valid = 1'b1;
                byte_val   = rd_data_reg;
                if (idx_inc == fl_n_reg) begin
                    adv_state = next_from(1'b0, tail_reg, p1_reg, p2_reg);
                end
                if (byte_take) begin
                    idx_next = idx_inc;
                end
            end
            S_FTAIL: begin
                byte_valid = 1'b1;
                byte_val   = b_reg;
                adv_state  = next_from(1'b0, 1'b0, p1_reg, p2_reg);
            end
            S_P1C: begin
                byte_valid = 1'b1;
                byte_val   = cnt1_reg;
                adv_state  = S_P1B;
            end
            S_P1B: begin
                byte_valid = 1'b1;
                byte_val   = h1_reg;
                adv_state  = next_from(1'b0, 1'b0, 1'b0, p2_reg);
            end
            S_P2C: begin
                byte_valid = 1'b1;
                byte_val   = cnt2_reg;
                adv_state  = S_P2B;
            end
            S_P2B: begin
                byte_valid = 1'b1;
                byte_val   = b_reg;
                adv_state  = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (byte_take) begin
            state_next = adv_state;
        end
    end

    assign byte_last = (adv_state == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            have_held_reg <= 1'b0;
            held_reg      <= '0;
            gc_reg        <= '0;
            fl_n_reg      <= '0;
            tail_reg      <= 1'b0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            fin_reg       <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            have_held_reg <= have_held_next;
            held_reg      <= held_next;
            gc_reg        <= gc_next;
            fl_n_reg      <= fl_n_next;
            tail_reg      <= tail_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            fin_reg       <= fin_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt1_reg <= cnt1_next;
        cnt2_reg <= cnt2_next;
        h1_reg   <= h1_next;
        b_reg    <= b_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lit_mem[lit[LIT_AW-1:0]] <= held_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= lit_mem[idx_next[LIT_AW-1:0]];
    end

    assign pk_full   = (pk_cnt_reg == NBYTES_W'(WORD_BYTES)) || pk_done_reg;
    assign xfer      = pk_full && (!m_valid_reg || m_ready);
    assign pack_free = !pk_full || xfer;
    assign byte_take = byte_valid && pack_free;

    always_comb begin
        pk_word_next = pk_word_reg;
        pk_cnt_next  = pk_cnt_reg;
        pk_done_next = pk_done_reg;
        pk_fin_next  = pk_fin_reg;
        if (xfer) begin
            pk_word_next = '0;
            pk_cnt_next  = '0;
            pk_done_next = 1'b0;
            pk_fin_next  = 1'b0;
        end
        pk_pos = pk_cnt_next[POS_W-1:0];
        if (byte_take) begin
            pk_word_next[{pk_pos, 3'b000} +: BYTE_W] = byte_val;
            pk_cnt_next  = pk_cnt_next + NBYTES_W'(1);
            pk_done_next = byte_last;
            pk_fin_next  = fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pk_word_reg <= '0;
            pk_cnt_reg  <= '0;
            pk_done_reg <= 1'b0;
            pk_fin_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pk_word_reg <= pk_word_next;
            pk_cnt_reg  <= pk_cnt_next;
            pk_done_reg <= pk_done_next;
            pk_fin_reg  <= pk_fin_next;
            m_valid_reg <= xfer || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer) begin
            m_word_reg  <= pk_word_reg;
            m_bytes_reg <= pk_cnt_reg;
            m_last_reg  <= pk_done_reg;
            m_end_reg   <= pk_done_reg && pk_fin_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_word  = m_word_reg;
    assign m_out_bytes = m_bytes_reg;
    assign m_run_last  = m_last_reg;
    assign m_frame_end = m_end_reg;

endmodule
